// ===== rtl/core/sdsd_pkg.sv =====
package sdsd_pkg;

  // Command codes carried on in_tuser
  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_SCORE = 3'd1,
    MODE_BITMAP = 3'd2,
    MODE_SET   = 3'd3,
    MODE_RESEND = 3'd4,
    MODE_BLINK = 3'd5
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_PEND = 2'd1,
    STAT_ERR  = 2'd2
  } stat_t;

  localparam int unsigned NUM_BYTES = 5;
  localparam int unsigned LAST_POS  = NUM_BYTES - 1;

  localparam logic [15:0] TOGGLE_GAP_RST = 16'd500;
  localparam logic [7:0]  SCORE_LIMIT    = 8'd100;
  localparam logic [2:0]  MAX_INDEX      = 3'd4;

  // Divide by ten as multiply by 205 and shift right by 11 (exact below 100)
  localparam logic [15:0] DIV10_MUL   = 16'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  // One queued job: a five-byte frame or a single status-only result.
  // bytes[0] goes out first.
  typedef struct packed {
    logic                 frame;
    stat_t                status;
    logic [NUM_BYTES-1:0][7:0] bytes;
  } job_t;

  // Seven-segment pattern of one decimal digit
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0: seg = 8'h7B;
      4'd1: seg = 8'h50;
      4'd2: seg = 8'hB3;
      4'd3: seg = 8'hF2;
      4'd4: seg = 8'hD8;
      4'd5: seg = 8'hEA;
      4'd6: seg = 8'hEB;
      4'd7: seg = 8'h70;
      4'd8: seg = 8'hFB;
      4'd9: seg = 8'hFA;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  // Tens digit of a score below 100
  function automatic logic [3:0] tens_of(input logic [7:0] score);
    logic [15:0] prod;
    prod = {8'd0, score} * DIV10_MUL;
    return prod[DIV10_SHIFT +: 4];
  endfunction

  // Ones digit of a score below 100
  function automatic logic [3:0] ones_of(input logic [7:0] score);
    logic [7:0] tens_x10;
    logic [7:0] rem;
    tens_x10 = {4'd0, tens_of(score)} * 8'd10;
    rem = score - tens_x10;
    return rem[3:0];
  endfunction

endpackage

// ===== rtl/core/score_display_shift_driver.sv =====
// Score display shift driver: takes one command request per cycle on the in_ stream
// and returns, per request, either a five-byte frame (stored bytes 3, 2, 1, 0, then 4,
// byte_valid set, tlast on the fifth) or a single status-only result with tlast set.
// The command decoder updates the display and blink state in the cycle a request is
// accepted and places a job in a QUEUE_DEPTH-entry queue; the output sequencer then
// sends one result per cycle while out_tready is high. A job is written into the queue and
// then loaded into the output register before its first result appears.
// in_tready falls only when the queue is full. The blink toggle interval is written on
// the cfg_ port (reset value 500) and should only change while no request is in flight.
module score_display_shift_driver #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // now_time[31:0], first_score[39:32], second_score[47:40], pattern_a[55:48],
  // pattern_b[63:56], pattern_c[71:64], pattern_d[79:72], byte_index[82:80],
  // blink_length[114:83], zero fill[119:115]
  input  logic [119:0] in_tdata,
  // mode[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // segment_byte[7:0]
  output logic [7:0]   out_tdata,
  // byte_valid[0], status[2:1]
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  logic           accept;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  sdsd_pkg::job_t front_job;
  sdsd_pkg::job_t head_job;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  sdsd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .mode         (in_tuser),
    .now_time     (in_tdata[31:0]),
    .first_score  (in_tdata[39:32]),
    .second_score (in_tdata[47:40]),
    .pattern_a    (in_tdata[55:48]),
    .pattern_b    (in_tdata[63:56]),
    .pattern_c    (in_tdata[71:64]),
    .pattern_d    (in_tdata[79:72]),
    .byte_index   (in_tdata[82:80]),
    .blink_length (in_tdata[114:83]),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .job          (front_job)
  );

  sdsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (front_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (head_job),
    .empty (q_empty)
  );

  sdsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (head_job),
    .job_avail  (!q_empty),
    .job_take   (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/sdsd_front.sv =====
module sdsd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [2:0]          mode,
  input  logic [31:0]         now_time,
  input  logic [7:0]          first_score,
  input  logic [7:0]          second_score,
  input  logic [7:0]          pattern_a,
  input  logic [7:0]          pattern_b,
  input  logic [7:0]          pattern_c,
  input  logic [7:0]          pattern_d,
  input  logic [2:0]          byte_index,
  input  logic [31:0]         blink_length,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  output sdsd_pkg::job_t      job
);

  logic [sdsd_pkg::NUM_BYTES-1:0][7:0] stored_r, stored_nxt;
  logic        blink_active_r, blink_active_nxt;
  logic        showing_blank_r, showing_blank_nxt;
  logic [31:0] next_toggle_r, next_toggle_nxt;
  logic [31:0] blink_end_r, blink_end_nxt;
  logic [15:0] interval_r;
  logic        send_frame;
  logic        send_blank;
  sdsd_pkg::stat_t status;

  // Decode the request, update the display state and build the job
  always_comb begin
    stored_nxt        = stored_r;
    blink_active_nxt  = blink_active_r;
    showing_blank_nxt = showing_blank_r;
    next_toggle_nxt   = next_toggle_r;
    blink_end_nxt     = blink_end_r;
    send_frame        = 1'b0;
    send_blank        = 1'b0;
    status            = sdsd_pkg::STAT_DONE;
    if (accept) begin
      case (sdsd_pkg::mode_t'(mode))
        sdsd_pkg::MODE_TICK: begin
          if (!blink_active_r) begin
            status = sdsd_pkg::STAT_DONE;
          end else if (now_time > blink_end_r) begin
            // window over: stop and show the stored frame
            blink_active_nxt  = 1'b0;
            showing_blank_nxt = 1'b0;
            send_frame        = 1'b1;
          end else if (now_time > next_toggle_r) begin
            showing_blank_nxt = !showing_blank_r;
            next_toggle_nxt   = now_time + {16'd0, interval_r};
            send_frame        = 1'b1;
            send_blank        = !showing_blank_r;
            status            = sdsd_pkg::STAT_PEND;
          end else begin
            status = sdsd_pkg::STAT_PEND;
          end
        end
        sdsd_pkg::MODE_SCORE: begin
          if (first_score >= sdsd_pkg::SCORE_LIMIT ||
              second_score >= sdsd_pkg::SCORE_LIMIT) begin
            status = sdsd_pkg::STAT_ERR;
          end else begin
            stored_nxt[0] = sdsd_pkg::seg_of(sdsd_pkg::ones_of(second_score));
            stored_nxt[1] = sdsd_pkg::seg_of(sdsd_pkg::tens_of(second_score));
            stored_nxt[2] = sdsd_pkg::seg_of(sdsd_pkg::ones_of(first_score));
            stored_nxt[3] = sdsd_pkg::seg_of(sdsd_pkg::tens_of(first_score));
            send_frame    = 1'b1;
          end
        end
        sdsd_pkg::MODE_BITMAP: begin
          stored_nxt[0] = pattern_a;
          stored_nxt[1] = pattern_b;
          stored_nxt[2] = pattern_c;
          stored_nxt[3] = pattern_d;
          send_frame    = 1'b1;
        end
        sdsd_pkg::MODE_SET: begin
          if (byte_index > sdsd_pkg::MAX_INDEX) begin
            status = sdsd_pkg::STAT_ERR;
          end else begin
            stored_nxt[byte_index] = pattern_a;
          end
        end
        sdsd_pkg::MODE_RESEND: begin
          send_frame = 1'b1;
        end
        sdsd_pkg::MODE_BLINK: begin
          blink_end_nxt    = now_time + blink_length;
          blink_active_nxt = 1'b1;
          status           = sdsd_pkg::STAT_PEND;
        end
        default: begin
          status = sdsd_pkg::STAT_ERR;
        end
      endcase
    end

    // Send order is stored byte 3, 2, 1, 0, then 4
    job.frame  = send_frame;
    job.status = status;
    if (send_frame && !send_blank) begin
      job.bytes = {stored_nxt[4], stored_nxt[0], stored_nxt[1],
                   stored_nxt[2], stored_nxt[3]};
    end else begin
      job.bytes = '0;
    end
  end

  // Hold display state and the blink interval
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r        <= '0;
      blink_active_r  <= 1'b0;
      showing_blank_r <= 1'b0;
      next_toggle_r   <= '0;
      blink_end_r     <= '0;
      interval_r      <= sdsd_pkg::TOGGLE_GAP_RST;
    end else begin
      stored_r        <= stored_nxt;
      blink_active_r  <= blink_active_nxt;
      showing_blank_r <= showing_blank_nxt;
      next_toggle_r   <= next_toggle_nxt;
      blink_end_r     <= blink_end_nxt;
      if (cfg_we) begin
        interval_r <= cfg_data;
      end
    end
  end

endmodule

// ===== rtl/core/sdsd_queue.sv =====
module sdsd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sdsd_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output sdsd_pkg::job_t dout,
  output logic           empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sdsd_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/core/sdsd_back.sv =====
module sdsd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  sdsd_pkg::job_t job,
  input  logic           job_avail,
  output logic           job_take,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic [2:0]     out_tuser,
  output logic           out_tlast
);

  localparam logic [2:0] POS_LAST = 3'(sdsd_pkg::LAST_POS);

  sdsd_pkg::job_t cur_r, cur_nxt;
  logic           busy_r, busy_nxt;
  logic [2:0]     pos_r, pos_nxt;
  logic           is_last;
  logic           sent;

  assign is_last  = !cur_r.frame || (pos_r == POS_LAST);
  assign sent     = busy_r && out_tready;
  assign job_take = job_avail && (!busy_r || (sent && is_last));

  // Step through the current job one result per cycle while out_tready is high
  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    if (job_take) begin
      cur_nxt  = job;
      busy_nxt = 1'b1;
      pos_nxt  = '0;
    end else if (sent) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        cur_nxt.bytes = cur_r.bytes >> 8;
        pos_nxt       = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = cur_r.bytes[0];
  assign out_tuser  = {cur_r.status, cur_r.frame};
  assign out_tlast  = is_last;

endmodule

// ===== rtl/core/sdsd_checker.sv =====
module sdsd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [7:0]   out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // A status-only result always closes its request
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("status-only result without tlast");

  // Status-only results carry a zero byte
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 8'd0)
    else $error("status-only result with nonzero byte");

  // Frame bytes follow back to back until tlast
  a_frame_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[0] && !out_tlast |=>
      out_tvalid && out_tuser[0] && out_tuser[2:1] == $past(out_tuser[2:1]))
    else $error("frame broken before tlast");

  // Status code 3 is never produced
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:1] != 2'b11)
    else $error("invalid status code");

endmodule

bind score_display_shift_driver sdsd_checker u_sdsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
